@@ rtl/rmq_pkg.sv @@
// Shared types, constants and helpers for the rotation matrix to quaternion block.
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_W          = 18;
  localparam int OUT_W         = 18;
  localparam int DIFF_W        = IN_W + 1;   // sum or difference of two entries
  localparam int QUO_W         = OUT_W - 1;  // quotient bits kept before clamping

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_Z     = 2'd1,
    BR_Y     = 2'd2,
    BR_X     = 2'd3
  } branch_e;

  typedef struct packed {
    branch_e                  br;
    logic signed [DIFF_W-1:0] d0;
    logic signed [DIFF_W-1:0] d1;
    logic signed [DIFF_W-1:0] d2;
  } sq_side_t;

  typedef struct packed {
    branch_e          br;
    logic [QUO_W-1:0] half;
  } dv_side_t;

  // Saturation bound: 1.0, or the largest positive code if 1.0 does not fit.
  function automatic logic [QUO_W-1:0] sat_hi(input int frac);
    logic [QUO_W-1:0] r;
    if (frac < QUO_W) r = QUO_W'(1) << frac;
    else r = '1;
    return r;
  endfunction

endpackage

@@ rtl/rotation_matrix_to_quaternion.sv @@
// Top level: rotation matrix to unit quaternion, four-branch trace method.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  matrix  | in        | start_i & !busy_o    | m00_i .. m22_i, Q1.16 signed
//  quat    | out       | done_o (one cycle)   | qx_o qy_o qz_o qw_o, branch_o
//
// One item enters every cycle; busy_o stays low. Each item passes the front register,
// the root pipeline (one bit per stage), the divider lanes (one quotient bit per
// stage) and the output register. Reset clears only
// the valid bits. Results are shown for one cycle and are never held back.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [rmq_pkg::IN_W-1:0]  m00_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m01_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m02_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m10_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m11_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m12_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m20_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m21_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m22_i,
  output logic                             done_o,
  output logic signed [rmq_pkg::OUT_W-1:0] qx_o,
  output logic signed [rmq_pkg::OUT_W-1:0] qy_o,
  output logic signed [rmq_pkg::OUT_W-1:0] qz_o,
  output logic signed [rmq_pkg::OUT_W-1:0] qw_o,
  output logic [1:0]                       branch_o
);

  localparam int QN  = rmq_pkg::QUO_W;
  localparam int TW  = ((FRAC_BITS + 1 > 20) ? FRAC_BITS + 1 : 20) + 2;
  localparam int NW0 = TW - 1 + FRAC_BITS;
  localparam int NW  = NW0 + (NW0 % 2);
  localparam int RW  = NW / 2;
  localparam int MW  = rmq_pkg::DIFF_W;
  localparam int DW  = ((MW + FRAC_BITS > RW + 1 + QN) ? MW + FRAC_BITS : RW + 1 + QN) + 1;
  localparam int OW  = rmq_pkg::OUT_W;
  localparam logic [QN-1:0] HI = rmq_pkg::sat_hi(FRAC_BITS);

  logic                     fr_valid, sq_valid, dv_valid;
  logic [NW-1:0]            fr_rad;
  rmq_pkg::sq_side_t        fr_side, sq_side;
  logic [RW-1:0]            sq_root;
  logic [RW-2:0]            root_half;
  logic signed [MW-1:0]     dv_d [3];
  logic signed [OW-1:0]     dv_q [3];
  rmq_pkg::dv_side_t        dv_in_side, dv_side;
  logic signed [OW-1:0]     half_s;
  logic                     done_q;
  logic signed [OW-1:0]     qx_d, qy_d, qz_d, qw_d, qx_q, qy_q, qz_q, qw_q;
  logic [1:0]               br_q;

  assign busy_o = 1'b0;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .TW(TW), .NW(NW)) u_front (
    .clk_i, .rst_ni,
    .valid_i (start_i),
    .m00_i, .m01_i, .m02_i, .m10_i, .m11_i, .m12_i, .m20_i, .m21_i, .m22_i,
    .valid_o (fr_valid),
    .rad_o   (fr_rad),
    .side_o  (fr_side)
  );

  rmq_sqrt #(.NW(NW)) u_sqrt (
    .clk_i, .rst_ni,
    .valid_i (fr_valid),
    .rad_i   (fr_rad),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // main component is s/2, clamped to the bound
  always_comb begin
    root_half = sq_root[RW-1:1];
    dv_in_side.br   = sq_side.br;
    dv_in_side.half = (root_half > (RW-1)'(HI)) ? HI : QN'(root_half);
    dv_d[0] = sq_side.d0;
    dv_d[1] = sq_side.d1;
    dv_d[2] = sq_side.d2;
  end

  rmq_div #(.FRAC_BITS(FRAC_BITS), .RW(RW), .DW(DW)) u_div (
    .clk_i, .rst_ni,
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .d_i     (dv_d),
    .side_i  (dv_in_side),
    .valid_o (dv_valid),
    .q_o     (dv_q),
    .side_o  (dv_side)
  );

  // route lanes to components by branch
  always_comb begin
    half_s = $signed({1'b0, dv_side.half});
    unique case (dv_side.br)
      rmq_pkg::BR_TRACE: begin
        qw_d = half_s;  qx_d = dv_q[0]; qy_d = dv_q[1]; qz_d = dv_q[2];
      end
      rmq_pkg::BR_Z: begin
        qz_d = half_s;  qw_d = dv_q[0]; qx_d = dv_q[1]; qy_d = dv_q[2];
      end
      rmq_pkg::BR_Y: begin
        qy_d = half_s;  qw_d = dv_q[0]; qz_d = dv_q[1]; qx_d = dv_q[2];
      end
      default: begin
        qx_d = half_s;  qw_d = dv_q[0]; qy_d = dv_q[1]; qz_d = dv_q[2];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q <= qx_d;
    qy_q <= qy_d;
    qz_q <= qz_d;
    qw_q <= qw_d;
    br_q <= dv_side.br;
  end

  assign done_o   = done_q;
  assign qx_o     = qx_q;
  assign qy_o     = qy_q;
  assign qz_o     = qz_q;
  assign qw_o     = qw_q;
  assign branch_o = br_q;

endmodule

@@ rtl/rmq_front.sv @@
// Input stage: trace, branch pick, radicand and off-diagonal terms.
`timescale 1ns / 1ps
module rmq_front #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int TW        = 22,
  parameter int NW        = 38
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [rmq_pkg::IN_W-1:0]   m00_i,
  input  logic signed [rmq_pkg::IN_W-1:0]   m01_i,
  input  logic signed [rmq_pkg::IN_W-1:0]   m02_i,
  input  logic signed [rmq_pkg::IN_W-1:0]   m10_i,
  input  logic signed [rmq_pkg::IN_W-1:0]   m11_i,
  input  logic signed [rmq_pkg::IN_W-1:0]   m12_i,
  input  logic signed [rmq_pkg::IN_W-1:0]   m20_i,
  input  logic signed [rmq_pkg::IN_W-1:0]   m21_i,
  input  logic signed [rmq_pkg::IN_W-1:0]   m22_i,
  output logic                              valid_o,
  output logic [NW-1:0]                     rad_o,
  output rmq_pkg::sq_side_t                 side_o
);

  localparam int DW = rmq_pkg::DIFF_W;

  logic signed [TW-1:0] e00, e11, e22, trace, one_s, t;
  logic signed [DW-1:0] x01, x02, x10, x12, x20, x21;
  rmq_pkg::branch_e     br;
  rmq_pkg::sq_side_t    side_d, side_q;
  logic [NW-1:0]        rad_d, rad_q;
  logic                 valid_q;

  always_comb begin
    e00   = TW'(m00_i);
    e11   = TW'(m11_i);
    e22   = TW'(m22_i);
    one_s = TW'(1) <<< FRAC_BITS;
    trace = e00 + e11 + e22;
    x01 = DW'(m01_i);
    x02 = DW'(m02_i);
    x10 = DW'(m10_i);
    x12 = DW'(m12_i);
    x20 = DW'(m20_i);
    x21 = DW'(m21_i);
    // strict compares: ties fall to the later branch
    if (trace > 0) begin
      br = rmq_pkg::BR_TRACE;
      t  = trace + one_s;
    end else if (m22_i > m11_i && m22_i > m00_i) begin
      br = rmq_pkg::BR_Z;
      t  = e22 - e00 - e11 + one_s;
    end else if (m11_i > m00_i) begin
      br = rmq_pkg::BR_Y;
      t  = e11 - e22 - e00 + one_s;
    end else begin
      br = rmq_pkg::BR_X;
      t  = e00 - e11 - e22 + one_s;
    end
    rad_d = (t > 0) ? (NW'(t[TW-2:0]) << FRAC_BITS) : '0;
    side_d.br = br;
    unique case (br)
      rmq_pkg::BR_TRACE: begin
        side_d.d0 = x21 - x12;
        side_d.d1 = x02 - x20;
        side_d.d2 = x10 - x01;
      end
      rmq_pkg::BR_Z: begin
        side_d.d0 = x10 - x01;
        side_d.d1 = x02 + x20;
        side_d.d2 = x12 + x21;
      end
      rmq_pkg::BR_Y: begin
        side_d.d0 = x02 - x20;
        side_d.d1 = x21 + x12;
        side_d.d2 = x01 + x10;
      end
      default: begin
        side_d.d0 = x21 - x12;
        side_d.d1 = x10 + x01;
        side_d.d2 = x20 + x02;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    side_q <= side_d;
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

@@ rtl/rmq_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rmq_sqrt #(
  parameter int NW = 38
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [NW-1:0]       rad_i,
  input  rmq_pkg::sq_side_t   side_i,
  output logic                valid_o,
  output logic [NW/2-1:0]     root_o,
  output rmq_pkg::sq_side_t   side_o
);

  localparam int RW = NW / 2;
  localparam int XW = RW + 3;

  logic                valid_q [RW];
  logic [NW-1:0]       n_q     [RW];
  logic [XW-1:0]       rem_q   [RW];
  logic [RW-1:0]       root_q  [RW];
  rmq_pkg::sq_side_t   side_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic              v_in;
    logic [NW-1:0]     n_in;
    logic [XW-1:0]     rem_in, rem_sh, trial;
    logic [RW-1:0]     root_in;
    rmq_pkg::sq_side_t s_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign n_in    = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign n_in    = n_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign s_in    = side_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    always_comb begin
      rem_sh = {rem_in[XW-3:0], n_in[NW-1:NW-2]};
      trial  = {1'b0, root_in, 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[k]    <= {n_in[NW-3:0], 2'b00};
      rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
      root_q[k] <= {root_in[RW-2:0], ge};
      side_q[k] <= s_in;
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

@@ rtl/rmq_div.sv @@
// Three pipelined restoring divider lanes: d * 0.5 / s, saturated.
`timescale 1ns / 1ps
module rmq_div #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int RW        = 19,
  parameter int DW        = 38
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [RW-1:0]                        root_i,
  input  logic signed [rmq_pkg::DIFF_W-1:0]    d_i     [3],
  input  rmq_pkg::dv_side_t                    side_i,
  output logic                                 valid_o,
  output logic signed [rmq_pkg::OUT_W-1:0]     q_o     [3],
  output rmq_pkg::dv_side_t                    side_o
);

  localparam int QN = rmq_pkg::QUO_W;
  localparam int MW = rmq_pkg::DIFF_W;
  localparam logic [QN-1:0] HI = rmq_pkg::sat_hi(FRAC_BITS);

  logic              valid_q [QN+1];
  rmq_pkg::dv_side_t side_q  [QN+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QN; k++) valid_q[k] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int k = 1; k <= QN; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    for (int k = 1; k <= QN; k++) side_q[k] <= side_q[k-1];
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [DW-1:0] rem_q  [QN+1];
    logic [RW:0]   den_q  [QN+1];
    logic [QN-1:0] quo_q  [QN+1];
    logic          ovf_q  [QN+1];
    logic          zero_q [QN+1];
    logic          neg_q  [QN+1];
    logic [MW-1:0] mag;
    logic [DW-1:0] num;
    logic [RW:0]   den2;
    logic [QN-1:0] qmag;

    // entry: magnitude, scaled numerator, and the overflow check against 2s<<QN
    always_comb begin
      mag  = d_i[l][MW-1] ? MW'(-d_i[l]) : MW'(d_i[l]);
      num  = DW'(mag) << FRAC_BITS;
      den2 = {root_i, 1'b0};
    end

    always_ff @(posedge clk_i) begin
      rem_q[0]  <= num;
      den_q[0]  <= den2;
      quo_q[0]  <= '0;
      ovf_q[0]  <= (num >= (DW'(den2) << QN));
      zero_q[0] <= (d_i[l] == '0);
      neg_q[0]  <= d_i[l][MW-1];
    end

    for (genvar k = 0; k < QN; k++) begin : g_step
      logic [DW-1:0] dsh;
      logic          ge;

      always_comb begin
        dsh = DW'(den_q[k]) << (QN - 1 - k);
        ge  = (rem_q[k] >= dsh);
      end

      always_ff @(posedge clk_i) begin
        rem_q[k+1]  <= ge ? (rem_q[k] - dsh) : rem_q[k];
        den_q[k+1]  <= den_q[k];
        quo_q[k+1]  <= {quo_q[k][QN-2:0], ge};
        ovf_q[k+1]  <= ovf_q[k];
        zero_q[k+1] <= zero_q[k];
        neg_q[k+1]  <= neg_q[k];
      end
    end

    always_comb begin
      qmag = (ovf_q[QN] || quo_q[QN] > HI) ? HI : quo_q[QN];
      if (zero_q[QN]) q_o[l] = '0;
      else if (neg_q[QN]) q_o[l] = -$signed({1'b0, qmag});
      else q_o[l] = $signed({1'b0, qmag});
    end
  end

  assign valid_o = valid_q[QN];
  assign side_o  = side_q[QN];

endmodule

@@ rtl/rmq_checker.sv @@
// Port-level checks for the rotation matrix to quaternion block, with bind.
`timescale 1ns / 1ps
module rmq_checker #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int LAT       = 39
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             done_o,
  input logic signed [rmq_pkg::OUT_W-1:0] qx_o,
  input logic signed [rmq_pkg::OUT_W-1:0] qy_o,
  input logic signed [rmq_pkg::OUT_W-1:0] qz_o,
  input logic signed [rmq_pkg::OUT_W-1:0] qw_o,
  input logic [1:0]                       branch_o
);

  localparam logic signed [rmq_pkg::OUT_W-1:0] HI =
    $signed({1'b0, rmq_pkg::sat_hi(FRAC_BITS)});

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("block refused an item");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without a matching item");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (qx_o <= HI && qx_o >= -HI && qy_o <= HI && qy_o >= -HI &&
                qz_o <= HI && qz_o >= -HI && qw_o <= HI && qw_o >= -HI))
    else $error("component beyond saturation bound");

  a_main_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((branch_o == rmq_pkg::BR_TRACE && !qw_o[rmq_pkg::OUT_W-1]) ||
                (branch_o == rmq_pkg::BR_Z && !qz_o[rmq_pkg::OUT_W-1]) ||
                (branch_o == rmq_pkg::BR_Y && !qy_o[rmq_pkg::OUT_W-1]) ||
                (branch_o == rmq_pkg::BR_X && !qx_o[rmq_pkg::OUT_W-1])))
    else $error("main component negative");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
  .FRAC_BITS (FRAC_BITS),
  .LAT       (RW + QN + 3)
) u_rmq_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o,
  .qx_o, .qy_o, .qz_o, .qw_o, .branch_o
);

@@ tb/rotation_matrix_to_quaternion_test.sv @@
// Self-checking testbench for the rotation matrix to quaternion block.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_test;

  localparam int FRAC  = rmq_pkg::FRAC_BITS_DEF;
  localparam int NDIR  = 18;
  localparam int NRAND = 450;
  localparam int WDOG  = 2000;

  typedef logic signed [rmq_pkg::IN_W-1:0]  ent_t;
  typedef logic signed [rmq_pkg::OUT_W-1:0] comp_t;

  typedef struct packed {
    comp_t            qx, qy, qz, qw;
    rmq_pkg::branch_e br;
  } quat_t;

  typedef struct {
    ent_t  m [9];
    logic  known;
    quat_t q;
  } stim_row_t;

  logic clk_i = 1'b0, rst_ni = 1'b0, start_i = 1'b0;
  logic busy_o, done_o;
  ent_t m_i [9];
  comp_t qx_o, qy_o, qz_o, qw_o;
  logic [1:0] branch_o;

  quat_t quat_q[$];
  int fails = 0;
  int idle_cycles = 0;
  stim_row_t dir_tab [NDIR];

  rotation_matrix_to_quaternion dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .m00_i(m_i[0]), .m01_i(m_i[1]), .m02_i(m_i[2]),
    .m10_i(m_i[3]), .m11_i(m_i[4]), .m12_i(m_i[5]),
    .m20_i(m_i[6]), .m21_i(m_i[7]), .m22_i(m_i[8]),
    .done_o, .qx_o, .qy_o, .qz_o, .qw_o, .branch_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint quat_limit();
    longint one = longint'(1) << FRAC;
    longint lim = (longint'(1) << (rmq_pkg::OUT_W - 1)) - 1;
    return (one < lim) ? one : lim;
  endfunction

  function automatic longint root_floor(longint n);
    longint r = 0;
    for (int b = 31; b >= 0; b--) begin
      longint c = r | (longint'(1) << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  // d * 0.5 / s, truncated toward zero and saturated
  function automatic comp_t off_axis(longint d, longint s);
    longint hi = quat_limit();
    longint mag = (d < 0) ? -d : d;
    longint qt;
    if (d == 0) return '0;
    if (s == 0) return comp_t'((d > 0) ? hi : -hi);
    qt = (mag << FRAC) / (2 * s);
    if (qt > hi) qt = hi;
    return comp_t'((d < 0) ? -qt : qt);
  endfunction

  function automatic quat_t matrix_to_quat(ent_t m [9]);
    longint e [9];
    longint one = longint'(1) << FRAC;
    longint t, s, h;
    quat_t q;
    for (int i = 0; i < 9; i++) e[i] = longint'(m[i]);
    t = e[0] + e[4] + e[8];
    if (t > 0) begin
      q.br = rmq_pkg::BR_TRACE; t = t + one;
    end else if (e[8] > e[4] && e[8] > e[0]) begin
      q.br = rmq_pkg::BR_Z; t = e[8] - e[0] - e[4] + one;
    end else if (e[4] > e[0]) begin
      q.br = rmq_pkg::BR_Y; t = e[4] - e[8] - e[0] + one;
    end else begin
      q.br = rmq_pkg::BR_X; t = e[0] - e[4] - e[8] + one;
    end
    s = (t > 0) ? root_floor(t << FRAC) : 0;
    h = s >> 1;
    if (h > quat_limit()) h = quat_limit();
    case (q.br)
      rmq_pkg::BR_TRACE: begin
        q.qw = comp_t'(h);
        q.qx = off_axis(e[7] - e[5], s);
        q.qy = off_axis(e[2] - e[6], s);
        q.qz = off_axis(e[3] - e[1], s);
      end
      rmq_pkg::BR_Z: begin
        q.qz = comp_t'(h);
        q.qw = off_axis(e[3] - e[1], s);
        q.qx = off_axis(e[2] + e[6], s);
        q.qy = off_axis(e[5] + e[7], s);
      end
      rmq_pkg::BR_Y: begin
        q.qy = comp_t'(h);
        q.qw = off_axis(e[2] - e[6], s);
        q.qz = off_axis(e[7] + e[5], s);
        q.qx = off_axis(e[1] + e[3], s);
      end
      default: begin
        q.qx = comp_t'(h);
        q.qw = off_axis(e[7] - e[5], s);
        q.qy = off_axis(e[3] + e[1], s);
        q.qz = off_axis(e[6] + e[2], s);
      end
    endcase
    return q;
  endfunction

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic ent_t rand_entry(int mode);
    case (mode)
      0: return ent_t'(int'($urandom_range(0, 131072)) - 65536);
      1: return ent_t'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0: return ent_t'(65536);
          1: return -ent_t'(65536);
          2: return '0;
          3: return ent_t'(-131072);
          default: return ent_t'(131071);
        endcase
      end
    endcase
  endfunction

  // rows: nine entries in row-major order; known result where obvious
  function automatic stim_row_t mk(longint a, b, c, d, e, f, g, h, k,
                                   logic known = 1'b0, quat_t q = '0);
    stim_row_t r;
    r.m[0] = ent_t'(a); r.m[1] = ent_t'(b); r.m[2] = ent_t'(c);
    r.m[3] = ent_t'(d); r.m[4] = ent_t'(e); r.m[5] = ent_t'(f);
    r.m[6] = ent_t'(g); r.m[7] = ent_t'(h); r.m[8] = ent_t'(k);
    r.known = known; r.q = q;
    return r;
  endfunction

  // drop start only across a gap, so back-to-back items keep it high
  task automatic send(ent_t m [9], quat_t q);
    int g = gap_len();
    if (g > 0) begin
      start_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    m_i = m;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    quat_q.push_back(q);
    @(negedge clk_i);
  endtask

  // check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      quat_t a, x;
      a.qx = qx_o; a.qy = qy_o; a.qz = qz_o; a.qw = qw_o;
      a.br = rmq_pkg::branch_e'(branch_o);
      if (quat_q.size() == 0) begin
        $display("%0t: unexpected item qx=%0d qy=%0d qz=%0d qw=%0d br=%0d",
                 $time, a.qx, a.qy, a.qz, a.qw, a.br);
        fails++;
      end else begin
        x = quat_q.pop_front();
        if (a.qx !== x.qx) begin
          $display("%0t: qx expected %0d got %0d", $time, x.qx, a.qx); fails++;
        end
        if (a.qy !== x.qy) begin
          $display("%0t: qy expected %0d got %0d", $time, x.qy, a.qy); fails++;
        end
        if (a.qz !== x.qz) begin
          $display("%0t: qz expected %0d got %0d", $time, x.qz, a.qz); fails++;
        end
        if (a.qw !== x.qw) begin
          $display("%0t: qw expected %0d got %0d", $time, x.qw, a.qw); fails++;
        end
        if (a.br !== x.br) begin
          $display("%0t: branch expected %0d got %0d", $time, x.br, a.br); fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WDOG) begin
      $display("[rotation_matrix_to_quaternion] ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t r;
    quat_t q;
    ent_t m [9];
    int mode;
    int k;
    for (int i = 0; i < 9; i++) m_i[i] = '0;
    // identity, and the identity with two diagonal entries negated for each diagonal branch
    dir_tab[0]  = mk(65536, 0, 0, 0, 65536, 0, 0, 0, 65536, 1,
                     '{qx: 0, qy: 0, qz: 0, qw: 65536, br: rmq_pkg::BR_TRACE});
    dir_tab[1]  = mk(-65536, 0, 0, 0, -65536, 0, 0, 0, 65536, 1,
                     '{qx: 0, qy: 0, qz: 65536, qw: 0, br: rmq_pkg::BR_Z});
    dir_tab[2]  = mk(-65536, 0, 0, 0, 65536, 0, 0, 0, -65536, 1,
                     '{qx: 0, qy: 65536, qz: 0, qw: 0, br: rmq_pkg::BR_Y});
    dir_tab[3]  = mk(65536, 0, 0, 0, -65536, 0, 0, 0, -65536, 1,
                     '{qx: 65536, qy: 0, qz: 0, qw: 0, br: rmq_pkg::BR_X});
    // all-zero matrix: trace zero, ties fall to the x branch
    dir_tab[4]  = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
    // ties on the diagonal
    dir_tab[5]  = mk(-100, 5, 6, 7, -100, 8, 9, 10, -200);
    dir_tab[6]  = mk(-300, 5, 6, 7, -100, 8, 9, 10, -100);
    // negative diagonals, x branch; in the second row one off-diagonal term saturates
    dir_tab[7]  = mk(-131072, 400, -300, -500, -131072, 7, 3, -2, -131072);
    dir_tab[8]  = mk(0, 131071, -131072, -131072, -65536, 131071, 131071,
                     -131072, -65536);
    // s just below 2.0 on the z branch
    dir_tab[9]  = mk(-65535, 65536, -65536, -65536, -65536, 65536, 65536,
                     -65536, 65535);
    // extremes of the raw field range
    dir_tab[10] = mk(131071, 131071, 131071, 131071, 131071, 131071, 131071,
                     131071, 131071);
    dir_tab[11] = mk(-131072, -131072, -131072, -131072, -131072, -131072,
                     -131072, -131072, -131072);
    dir_tab[12] = mk(131071, -131072, 131071, -131072, -131072, 131071,
                     -131072, 131071, -131072);
    // rotations about each axis by 90 degrees
    dir_tab[13] = mk(0, -65536, 0, 65536, 0, 0, 0, 0, 65536);
    dir_tab[14] = mk(0, 0, 65536, 0, 65536, 0, -65536, 0, 0);
    dir_tab[15] = mk(65536, 0, 0, 0, 0, -65536, 0, 65536, 0);
    // trace of exactly one count, and of minus one count
    dir_tab[16] = mk(1, 11, -22, 33, 0, -44, 55, -66, 0);
    dir_tab[17] = mk(-1, 12345, -23456, 34567, -1, 45678, -56789, 61234, 1);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      q = r.known ? r.q : matrix_to_quat(r.m);
      send(r.m, q);
    end

    for (int n = 0; n < NRAND; n++) begin
      mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
      for (int i = 0; i < 9; i++) m[i] = rand_entry(mode);
      // steer toward each diagonal branch
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) m[4 * i] = -ent_t'($urandom_range(0, 65536));
        m[4 * k] = ent_t'($urandom_range(0, 65536));
      end
      send(m, matrix_to_quat(m));
    end
    start_i <= 1'b0;

    while (quat_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fails == 0) $display("[rotation_matrix_to_quaternion] OK");
    else $display("[rotation_matrix_to_quaternion] ERROR");
    $finish;
  end
endmodule
